// ===== rtl/ssfr_pkg.sv =====
// Shared constants, codes and field types for the single-slot reservation core.
// No dependencies; every other file in this block imports this package.
package ssfr_pkg;

   localparam int QUEUE_DEPTH = 16;

   localparam int ID_W     = 32;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;
   localparam int WCOUNT_W = 5;

   // Internal occupancy counter and physical pointer widths.
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   typedef logic [ID_W-1:0]     id_type;
   typedef logic [ACTION_W-1:0] action_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [WCOUNT_W-1:0] wcount_type;

   localparam action_type ACT_REQUEST = 2'd0;
   localparam action_type ACT_RELEASE = 2'd1;
   localparam action_type ACT_CLEAR   = 2'd2;

   localparam status_type ST_PRESENT  = 3'd0;
   localparam status_type ST_ACTIVE   = 3'd1;
   localparam status_type ST_QUEUED   = 3'd2;
   localparam status_type ST_FULL     = 3'd3;
   localparam status_type ST_REMOVED  = 3'd4;
   localparam status_type ST_NOCHANGE = 3'd5;

endpackage

// ===== rtl/ssfr_channels.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on ssfr_pkg for field types.
interface ssfr_req_if;
   import ssfr_pkg::*;

   logic       valid;
   logic       ready;
   action_type action;
   id_type     client_id;

   modport source (output valid, output action, output client_id, input ready);
   modport sink   (input valid, input action, input client_id, output ready);
endinterface

interface ssfr_rsp_if;
   import ssfr_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   id_type     active_id;
   wcount_type waiting_count;
   logic       promoted;

   modport source (output valid, output status, output active_id,
                   output waiting_count, output promoted, input ready);
   modport sink   (input valid, input status, input active_id,
                   input waiting_count, input promoted, output ready);
endinterface

// ===== rtl/single_slot_fifo_reservation_core.sv =====
// Single-slot reservation with a bounded first-come wait queue held in a RAM.
// Depends on ssfr_pkg and the channel interfaces in ssfr_channels.sv.
//
//   Channel   Dir  Contents                                   Transfer when
//   req_chan  in   action, client_id                          valid && ready
//   rsp_chan  out  status, active_id, waiting_count, promoted valid && ready
//
// One item at a time. Clear, id zero, a request to a free slot and a release
// of the holder need no queue walk (a release with waiters first reads the
// head waiter to promote it). A request that must search the queue and a
// release of a waiter walk the waiters entry by entry, limited by the single
// read port of the queue RAM.
// Reset is synchronous and empties the slot and the queue; no clearing pass.
// A result waits in the output register until taken; the next request is
// accepted meanwhile and its own result holds until the register frees.
module single_slot_fifo_reservation_core (
   input logic     clock,
   input logic     reset,
   ssfr_req_if.sink   req_chan,
   ssfr_rsp_if.source rsp_chan
);
   import ssfr_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_HEAD  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   // Physical slot of logical queue position pos, counted from the head.
   function automatic logic [PTR_W-1:0] phys(input logic [PTR_W-1:0] head,
                                             input logic [CNT_W-1:0] pos);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(head) + (CNT_W+1)'(pos);
      if (s >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         s = s - (CNT_W+1)'(QUEUE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   logic [2:0]       state_ff, state_in;
   id_type           act_ff, act_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   action_type       action_ff, action_in;
   id_type           id_ff, id_in;
   status_type       status_ff, status_in;
   logic             promoted_ff, promoted_in;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   id_type           rsp_active_ff, rsp_active_in;
   wcount_type       rsp_count_ff, rsp_count_in;
   logic             rsp_promoted_ff, rsp_promoted_in;

   id_type           wait_mem [QUEUE_DEPTH];
   id_type           rd_data_ff;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   id_type           wr_data;

   logic             hit;
   logic             scan_issue;
   logic [CNT_W-1:0] idx_nxt;
   logic             shift_issue;
   logic [CNT_W+WCOUNT_W-1:0] cnt_ext;

   assign hit         = rd_valid_ff && (rd_data_ff == id_ff);
   assign scan_issue  = idx_ff < cnt_ff;
   assign idx_nxt     = CNT_W'(idx_ff + 1'b1);
   assign shift_issue = idx_nxt < cnt_ff;
   assign cnt_ext     = {{WCOUNT_W{1'b0}}, cnt_ff};

   always_comb begin
      state_in        = state_ff;
      act_in          = act_ff;
      cnt_in          = cnt_ff;
      head_in         = head_ff;
      idx_in          = idx_ff;
      rd_valid_in     = 1'b0;
      rd_idx_in       = rd_idx_ff;
      action_in       = action_ff;
      id_in           = id_ff;
      status_in       = status_ff;
      promoted_in     = promoted_ff;
      rd_en           = 1'b0;
      rd_addr         = head_ff;
      wr_en           = 1'b0;
      wr_addr         = head_ff;
      wr_data         = id_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_chan.ready;
      rsp_status_in   = rsp_status_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_promoted_in = rsp_promoted_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               action_in   = req_chan.action;
               id_in       = req_chan.client_id;
               idx_in      = '0;
               promoted_in = 1'b0;
               case (req_chan.action)
                  ACT_REQUEST: begin
                     if (req_chan.client_id == '0 || req_chan.client_id == act_ff) begin
                        status_in = ST_PRESENT;
                        state_in  = S_DONE;
                     end else if (act_ff == '0) begin
                        // An empty slot implies an empty queue, so no search.
                        act_in    = req_chan.client_id;
                        status_in = ST_ACTIVE;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ACT_RELEASE: begin
                     if (req_chan.client_id == '0) begin
                        status_in = ST_NOCHANGE;
                        state_in  = S_DONE;
                     end else if (req_chan.client_id == act_ff) begin
                        if (cnt_ff != '0) begin
                           rd_en    = 1'b1;
                           rd_addr  = head_ff;
                           state_in = S_HEAD;
                        end else begin
                           act_in    = '0;
                           status_in = ST_REMOVED;
                           state_in  = S_DONE;
                        end
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  ACT_CLEAR: begin
                     act_in    = '0;
                     cnt_in    = '0;
                     head_in   = '0;
                     status_in = ST_REMOVED;
                     state_in  = S_DONE;
                  end
                  default: begin
                     status_in = ST_NOCHANGE;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // One read issued and one compare made per cycle.
            if (scan_issue) begin
               rd_en       = 1'b1;
               rd_addr     = phys(head_ff, idx_ff);
               rd_valid_in = 1'b1;
               rd_idx_in   = idx_ff;
               idx_in      = idx_nxt;
            end
            if (hit) begin
               rd_valid_in = 1'b0;
               if (action_ff == ACT_REQUEST) begin
                  status_in = ST_PRESENT;
                  state_in  = S_DONE;
               end else begin
                  idx_in   = rd_idx_ff;
                  state_in = S_SHIFT;
               end
            end else if (!scan_issue) begin
               if (action_ff == ACT_REQUEST) begin
                  if (cnt_ff == CNT_W'(QUEUE_DEPTH)) begin
                     status_in = ST_FULL;
                  end else begin
                     wr_en     = 1'b1;
                     wr_addr   = phys(head_ff, cnt_ff);
                     wr_data   = id_ff;
                     cnt_in    = CNT_W'(cnt_ff + 1'b1);
                     status_in = ST_QUEUED;
                  end
               end else begin
                  status_in = ST_NOCHANGE;
               end
               state_in = S_DONE;
            end
         end
         S_SHIFT: begin
            // Close the gap: each later entry moves down one place, read then write.
            if (shift_issue) begin
               rd_en       = 1'b1;
               rd_addr     = phys(head_ff, idx_nxt);
               rd_valid_in = 1'b1;
               rd_idx_in   = idx_ff;
               idx_in      = idx_nxt;
            end
            if (rd_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = phys(head_ff, rd_idx_ff);
               wr_data = rd_data_ff;
            end
            if (!shift_issue && !rd_valid_ff) begin
               cnt_in    = CNT_W'(cnt_ff - 1'b1);
               status_in = ST_REMOVED;
               state_in  = S_DONE;
            end
         end
         S_HEAD: begin
            act_in      = rd_data_ff;
            head_in     = phys(head_ff, CNT_W'(1));
            cnt_in      = CNT_W'(cnt_ff - 1'b1);
            promoted_in = 1'b1;
            status_in   = ST_REMOVED;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_active_in   = act_ff;
               rsp_count_in    = cnt_ext[WCOUNT_W-1:0];
               rsp_promoted_in = promoted_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         act_ff       <= '0;
         cnt_ff       <= '0;
         head_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         act_ff       <= act_in;
         cnt_ff       <= cnt_in;
         head_ff      <= head_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      rd_idx_ff       <= rd_idx_in;
      action_ff       <= action_in;
      id_ff           <= id_in;
      status_ff       <= status_in;
      promoted_ff     <= promoted_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_active_ff   <= rsp_active_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_promoted_ff <= rsp_promoted_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         wait_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= wait_mem[rd_addr];
      end
   end

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.active_id     = rsp_active_ff;
   assign rsp_chan.waiting_count = rsp_count_ff;
   assign rsp_chan.promoted      = rsp_promoted_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");

   a_free_slot_empty_queue: assert property (@(posedge clock) disable iff (reset)
      (act_ff == '0) |-> (cnt_ff == '0))
      else $error("waiters present while the slot is free");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
      else $error("accepted transfer did not start work");

   a_promoted_has_holder: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_promoted_ff) |-> (rsp_active_ff != '0))
      else $error("promotion reported with a free slot");

   a_read_pipe_in_walk: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == S_SCAN || state_ff == S_SHIFT))
      else $error("queue read in flight outside a queue walk");

endmodule
